@@ src/vector_project_reflect_defines.svh @@
// Assertion macros for the vector projection block's checker.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef VECTOR_PROJECT_REFLECT_DEFINES_SVH
`define VECTOR_PROJECT_REFLECT_DEFINES_SVH

// Overlapping implication; cons may start with a ## delay.
`define VPR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// Plain invariant sampled at every edge out of reset.
`define VPR_ASSERT_ALW(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

@@ src/vpr_pkg.sv @@
// Package for the vector projection / reflection block: widths, mode codes,
// and the structs passed between front end, queue and back end. No dependencies.
package vpr_pkg;

	localparam int MAX_DIM = 4;
	// numerator a.b and denominator b.b: 66-bit exact sums
	localparam int DW      = 66;
	// |a.b| * |b_i|: 66 x 32 bits
	localparam int NW      = DW + 32;
	// quotient magnitude never exceeds |a| <= 2^32, so 34 bits are enough
	localparam int QBITS   = 34;
	// input transfer to result strobe, in cycles
	localparam int LAT     = QBITS + 8;

	typedef enum logic [1:0] {
		MODE_PROJ = 2'd0,
		MODE_PERP = 2'd1,
		MODE_REFL = 2'd2
	} mode_t;

	// per-item data that travels alongside the divider lanes
	typedef struct packed {
		mode_t                     mode;
		logic                      zero;
		logic                      nneg;
		logic [MAX_DIM-1:0]        bneg;
		logic [MAX_DIM-1:0][31:0]  a;
		logic [MAX_DIM-1:0]        act;
	} side_t;

	// one classified item, front end to back end
	typedef struct packed {
		logic [DW-1:0]             anum;
		logic [DW-1:0]             den;
		logic [MAX_DIM-1:0][31:0]  bmag;
		side_t                     side;
	} entry_t;

endpackage

@@ src/vector_project_reflect.sv @@
// Top level of the vector projection / perpendicular / reflection block.
// Depends on vpr_pkg, vpr_front, vpr_queue, vpr_back (and vpr_div below it).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  input    | start, busy               | mode, a0..a3, b0..b3
//  result   | done (one-cycle strobe)   | r0..r3, zero_divisor
//  config   | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// One item per cycle; each result passes through the 34-stage divider pipeline
// in each of the four lanes on its way from transfer to done.
// arst_n clears all valid bits and sets active_dims to 3.
// The result side cannot stall, so the back end drains the queue every cycle
// and busy stays low in operation.
module vector_project_reflect import vpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] a0,
	input  logic [31:0] a1,
	input  logic [31:0] a2,
	input  logic [31:0] a3,
	input  logic [31:0] b0,
	input  logic [31:0] b1,
	input  logic [31:0] b2,
	input  logic [31:0] b3,
	output logic        done,
	output logic [31:0] r0,
	output logic [31:0] r1,
	output logic [31:0] r2,
	output logic [31:0] r3,
	output logic        zero_divisor,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0]               dims_q;
	logic                     take;
	logic                     push, pop, q_empty, q_full;
	entry_t                   ent_f, ent_b;
	logic [MAX_DIM-1:0][31:0] a_v, b_v, r_v;

	// register file: one register, active_dims, at byte addresses 0 to 3 (paddr[2] low)
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {29'd0, dims_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 3'd3;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			dims_q <= pwdata[2:0];
		end
	end

	assign busy = q_full;
	assign take = start && !busy;

	assign a_v = {a3, a2, a1, a0};
	assign b_v = {b3, b2, b1, b0};

	vpr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.mode   (mode),
		.a      (a_v),
		.b      (b_v),
		.dims   (dims_q),
		.push   (push),
		.ent    (ent_f)
	);

	// decouples classification from the divider pipeline
	vpr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (ent_f),
		.pop    (pop),
		.rdata  (ent_b),
		.empty  (q_empty),
		.full   (q_full)
	);

	vpr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (!q_empty),
		.ent    (ent_b),
		.pop    (pop),
		.done   (done),
		.r      (r_v),
		.zdiv   (zero_divisor)
	);

	assign r0 = r_v[0];
	assign r1 = r_v[1];
	assign r2 = r_v[2];
	assign r3 = r_v[3];

endmodule

@@ src/vpr_queue.sv @@
// Two-entry queue between front end and back end.
// Depends on vpr_pkg.
module vpr_queue import vpr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wdata,
	input  logic   pop,
	output entry_t rdata,
	output logic   empty,
	output logic   full
);

	entry_t     ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign rdata = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= wdata;
	end

endmodule

@@ src/vpr_front.sv @@
// Front end: masks inactive components, forms a.b and b.b, classifies the item.
// Depends on vpr_pkg.
module vpr_front import vpr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic [1:0]               mode,
	input  logic [MAX_DIM-1:0][31:0] a,
	input  logic [MAX_DIM-1:0][31:0] b,
	input  logic [2:0]               dims,
	output logic                     push,
	output entry_t                   ent
);

	logic [2:0]               dimc;
	logic [MAX_DIM-1:0]       act;
	logic [MAX_DIM-1:0][31:0] am;
	logic [MAX_DIM-1:0][31:0] bm;

	logic                     valid_s1, valid_s2, valid_s3;
	mode_t                    mode_s1, mode_s2;
	logic [MAX_DIM-1:0]       act_s1, act_s2;
	logic [MAX_DIM-1:0][31:0] a_s1, a_s2, b_s1, b_s2;
	logic signed [63:0]       pab_s1 [MAX_DIM];
	logic [63:0]              pbb_s1 [MAX_DIM];
	logic signed [DW-1:0]     num_s2;
	logic [DW-1:0]            den_s2;
	logic signed [DW-1:0]     num_sum;
	logic [DW-1:0]            den_sum;
	entry_t                   ent_s3;

	// out-of-range counts clamp to the nearest legal one
	always_comb begin
		if (dims < 3'd2) dimc = 3'd2;
		else if (dims > 3'(MAX_DIM)) dimc = 3'(MAX_DIM);
		else dimc = dims;
		for (int i = 0; i < MAX_DIM; i++) begin
			act[i] = (3'(i) < dimc);
			am[i]  = act[i] ? a[i] : 32'd0;
			bm[i]  = act[i] ? b[i] : 32'd0;
		end
	end

	always_comb begin
		num_sum = '0;
		den_sum = '0;
		for (int i = 0; i < MAX_DIM; i++) begin
			num_sum = num_sum + {{(DW-64){pab_s1[i][63]}}, pab_s1[i]};
			den_sum = den_sum + {{(DW-64){1'b0}}, pbb_s1[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode_t'(mode);
		act_s1  <= act;
		a_s1    <= am;
		b_s1    <= bm;
		for (int i = 0; i < MAX_DIM; i++) begin
			pab_s1[i] <= $signed(am[i]) * $signed(bm[i]);
			pbb_s1[i] <= $signed(bm[i]) * $signed(bm[i]);
		end

		mode_s2 <= mode_s1;
		act_s2  <= act_s1;
		a_s2    <= a_s1;
		b_s2    <= b_s1;
		num_s2  <= num_sum;
		den_s2  <= den_sum;

		ent_s3.anum      <= num_s2[DW-1] ? DW'(-num_s2) : DW'(num_s2);
		ent_s3.den       <= den_s2;
		ent_s3.side.mode <= mode_s2;
		ent_s3.side.zero <= (den_s2 == '0);
		ent_s3.side.nneg <= num_s2[DW-1];
		ent_s3.side.a    <= a_s2;
		ent_s3.side.act  <= act_s2;
		for (int i = 0; i < MAX_DIM; i++) begin
			ent_s3.side.bneg[i] <= b_s2[i][31];
			ent_s3.bmag[i]      <= b_s2[i][31] ? 32'(-b_s2[i]) : b_s2[i];
		end
	end

	assign push = valid_s3;
	assign ent  = ent_s3;

endmodule

@@ src/vpr_div.sv @@
// One divider lane: pipelined restoring division, one quotient bit per stage.
// Depends on vpr_pkg.
module vpr_div import vpr_pkg::*; (
	input  logic             clk,
	input  logic [NW-1:0]    n,
	input  logic [DW-1:0]    d,
	output logic [QBITS-1:0] q,
	output logic [DW-1:0]    rem,
	output logic [DW-1:0]    d_out
);

	logic [DW-1:0]    rem_q [1:QBITS];
	logic [QBITS-1:0] low_q [1:QBITS];
	logic [QBITS-1:0] quo_q [1:QBITS];
	logic [DW-1:0]    den_q [1:QBITS];

	for (genvar k = 0; k < QBITS; k++) begin : g_stage
		logic [DW-1:0]    rem_i, den_i;
		logic [QBITS-1:0] low_i, quo_i;
		logic [DW:0]      trial;
		logic             ge;

		if (k == 0) begin : g_first
			// top bits of n are known to be below d
			assign rem_i = DW'(n[NW-1:QBITS]);
			assign low_i = n[QBITS-1:0];
			assign quo_i = '0;
			assign den_i = d;
		end else begin : g_rest
			assign rem_i = rem_q[k];
			assign low_i = low_q[k];
			assign quo_i = quo_q[k];
			assign den_i = den_q[k];
		end

		assign trial = {rem_i, low_i[QBITS-1]};
		assign ge    = (trial >= {1'b0, den_i});

		always_ff @(posedge clk) begin
			rem_q[k+1] <= ge ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
			low_q[k+1] <= low_i << 1;
			quo_q[k+1] <= {quo_i[QBITS-2:0], ge};
			den_q[k+1] <= den_i;
		end
	end

	assign q     = quo_q[QBITS];
	assign rem   = rem_q[QBITS];
	assign d_out = den_q[QBITS];

endmodule

@@ src/vpr_back.sv @@
// Back end: scales |a.b| by |b_i|, divides by b.b, rounds, combines and saturates.
// Depends on vpr_pkg and vpr_div.
module vpr_back import vpr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     avail,
	input  entry_t                   ent,
	output logic                     pop,
	output logic                     done,
	output logic [MAX_DIM-1:0][31:0] r,
	output logic                     zdiv
);

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	side_t              side_s1, side_s2, side_s3;
	logic [DW-1:0]      den_s1, den_s2;
	logic [64:0]        plo_s1 [MAX_DIM];
	logic [64:0]        phi_s1 [MAX_DIM];
	logic [NW-1:0]      n_s2   [MAX_DIM];
	logic               valid_pipe_q [1:QBITS];
	side_t              side_pipe_q  [1:QBITS];
	logic [QBITS-1:0]   q_w    [MAX_DIM];
	logic [DW-1:0]      rem_w  [MAX_DIM];
	logic [DW-1:0]      dq_w   [MAX_DIM];
	logic signed [35:0] p_s3   [MAX_DIM];
	logic [MAX_DIM-1:0][31:0] r_s4;
	logic               zdiv_s4;

	assign pop = avail;

	for (genvar i = 0; i < MAX_DIM; i++) begin : g_lane
		vpr_div u_div (
			.clk   (clk),
			.n     (n_s2[i]),
			.d     (den_s2),
			.q     (q_w[i]),
			.rem   (rem_w[i]),
			.d_out (dq_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			for (int k = 1; k <= QBITS; k++) valid_pipe_q[k] <= 1'b0;
		end else begin
			valid_s1        <= avail;
			valid_s2        <= valid_s1;
			valid_pipe_q[1] <= valid_s2;
			for (int k = 2; k <= QBITS; k++) valid_pipe_q[k] <= valid_pipe_q[k-1];
			valid_s3        <= valid_pipe_q[QBITS];
			valid_s4        <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		// split product: two 33 x 32 partial products per lane
		side_s1 <= ent.side;
		den_s1  <= ent.den;
		for (int i = 0; i < MAX_DIM; i++) begin
			plo_s1[i] <= ent.anum[32:0] * ent.bmag[i];
			phi_s1[i] <= ent.anum[DW-1:33] * ent.bmag[i];
		end

		side_s2 <= side_s1;
		den_s2  <= den_s1;
		for (int i = 0; i < MAX_DIM; i++) begin
			n_s2[i] <= NW'(plo_s1[i]) + (NW'(phi_s1[i]) << 33);
		end

		side_pipe_q[1] <= side_s2;
		for (int k = 2; k <= QBITS; k++) side_pipe_q[k] <= side_pipe_q[k-1];

		// round half away from zero on the magnitude, then apply the sign
		side_s3 <= side_pipe_q[QBITS];
		for (int i = 0; i < MAX_DIM; i++) begin
			logic [34:0] qm;
			logic        up;
			up = ({rem_w[i], 1'b0} >= {1'b0, dq_w[i]});
			qm = {1'b0, q_w[i]} + 35'(up);
			p_s3[i] <= (side_pipe_q[QBITS].nneg ^ side_pipe_q[QBITS].bneg[i]) ?
				-$signed({1'b0, qm}) : $signed({1'b0, qm});
		end

		zdiv_s4 <= side_s3.zero;
		for (int i = 0; i < MAX_DIM; i++) begin
			logic signed [37:0] av, pv, t;
			av = 38'($signed(side_s3.a[i]));
			pv = 38'(p_s3[i]);
			case (side_s3.mode)
				MODE_PROJ: t = pv;
				MODE_PERP: t = av - pv;
				MODE_REFL: t = av - (pv <<< 1);
				default:   t = '0;
			endcase
			if (side_s3.zero || !side_s3.act[i]) r_s4[i] <= 32'd0;
			else if (t > 38'sd2147483647) r_s4[i] <= 32'h7FFF_FFFF;
			else if (t < -38'sd2147483648) r_s4[i] <= 32'h8000_0000;
			else r_s4[i] <= t[31:0];
		end
	end

	assign done = valid_s4;
	assign r    = r_s4;
	assign zdiv = zdiv_s4;

endmodule

@@ src/vpr_checker.sv @@
// Port-level checker for vector_project_reflect, attached by bind below.
// Depends on vpr_pkg and vector_project_reflect_defines.svh.
`include "vector_project_reflect_defines.svh"

module vpr_checker import vpr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] r0,
	input logic [31:0] r1,
	input logic [31:0] r2,
	input logic [31:0] r3,
	input logic        zero_divisor
);

	// every transfer yields a result after the fixed latency
	`VPR_ASSERT_IMP(a_latency, start && !busy, ##LAT done, "result missing after transfer")
	// no result without an earlier transfer
	`VPR_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, LAT), "result without transfer")
	// zero-length b forces all components to zero
	`VPR_ASSERT_IMP(a_zero_div, done && zero_divisor,
		(r0 == 32'd0 && r1 == 32'd0 && r2 == 32'd0 && r3 == 32'd0),
		"nonzero result with zero divisor")

endmodule

bind vector_project_reflect vpr_checker u_vpr_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench for vector_project_reflect: projection, perpendicular and reflection.
// Depends on vpr_pkg and the RTL; predicts each result and compares it on done.
module tb;
	import vpr_pkg::*;

	// mode code outside the enum; the block answers it with zeros
	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam logic [2:0] ADDR_DIMS = 3'd0;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [31:0] r [4];
		logic        zd;
	} vec_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [31:0] a0, a1, a2, a3, b0, b1, b2, b3;
	logic        done;
	logic [31:0] r0, r1, r2, r3;
	logic        zero_divisor;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// predictor's copy of active_dims
	logic [2:0]  dims_reg;
	vec_result_t expected_vecs[$];
	int          mismatches;
	int          cycles;
	bit          no_gaps;

	vector_project_reflect i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.a0(a0), .a1(a1), .a2(a2), .a3(a3), .b0(b0), .b1(b1), .b2(b2), .b3(b3),
		.done(done), .r0(r0), .r1(r1), .r2(r2), .r3(r3), .zero_divisor(zero_divisor),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Exact projection: num = a.b and den = b.b over the active components,
	// p_i = round(|num| * |b_i| / den) ties away, sign put on afterwards.
	function automatic vec_result_t project_vec(input logic [1:0] m,
			input logic [31:0] av [4], input logic [31:0] bv [4], input logic [2:0] dreg);
		vec_result_t res;
		int n;
		logic signed [127:0] num, den;
		logic [127:0] anum, bmag, prod, q, rem;
		longint ai, bi, p, r;
		bit neg;
		n = (dreg < 2) ? 2 : (dreg > MAX_DIM) ? MAX_DIM : int'(dreg);
		num = 0;
		den = 0;
		for (int i = 0; i < 4; i++)
			res.r[i] = 32'd0;
		for (int i = 0; i < n; i++) begin
			ai = $signed(av[i]);
			bi = $signed(bv[i]);
			num += ai * bi;
			den += bi * bi;
		end
		res.zd = (den == 0);
		if (res.zd || m == MODE_NONE)
			return res;
		anum = (num < 0) ? -num : num;
		for (int i = 0; i < n; i++) begin
			ai = $signed(av[i]);
			bi = $signed(bv[i]);
			bmag = (bi < 0) ? -bi : bi;
			prod = anum * bmag;
			q = prod / den;
			rem = prod - q * den;
			if ((rem << 1) >= den)
				q += 1;
			// quotient clamps at 2^40, far beyond any saturated result
			if (q > (128'd1 << 40))
				q = 128'd1 << 40;
			neg = (num < 0) != (bi < 0);
			p = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
			case (mode_t'(m))
				MODE_PROJ: r = p;
				MODE_PERP: r = ai - p;
				default:   r = ai - 2 * p;
			endcase
			if (r > 64'sd2147483647)
				r = 64'sd2147483647;
			if (r < -64'sd2147483648)
				r = -64'sd2147483648;
			res.r[i] = r[31:0];
		end
		return res;
	endfunction

	// One input transfer; start stays high when the caller sends again at once.
	task automatic send_vec(input logic [1:0] m, input logic [31:0] av [4],
			input logic [31:0] bv [4]);
		start <= 1'b1;
		mode <= m;
		a0 <= av[0]; a1 <= av[1]; a2 <= av[2]; a3 <= av[3];
		b0 <= bv[0]; b1 <= bv[1]; b2 <= bv[2]; b3 <= bv[3];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_vecs.push_back(project_vec(m, av, bv, dims_reg));
		// random gaps after ~14% of transfers: about 26% idle cycles
		if (!no_gaps && $urandom_range(99) < 14) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	// Let every pending transfer come back, then the pipeline settle.
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (expected_vecs.size() != 0)
			@(posedge clk);
		repeat (LAT + 4)
			@(posedge clk);
	endtask

	task automatic write_dims(input logic [2:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_DIMS;
		pwdata <= {29'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		dims_reg = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [31:0] rand_comp(input int kind);
		case (kind)
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return 32'd0;
			// a few units in Q16.16
			default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
		endcase
	endfunction

	// Extremes, every mode, zero divisor, zero only in the active part, saturation.
	task automatic test_directed;
		logic [31:0] av [4], bv [4];
		for (int m = 0; m < 4; m++) begin
			av = '{32'h7fffffff, 32'h80000000, 32'h00010000, 32'hffff0000};
			bv = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h00000001};
			send_vec(2'(m), av, bv);
			av = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
			bv = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
			send_vec(2'(m), av, bv);
			// b.b zero
			av = '{32'h00030000, 32'hfffd0000, 32'h7fffffff, 32'h1};
			bv = '{32'd0, 32'd0, 32'd0, 32'd0};
			send_vec(2'(m), av, bv);
			// b nonzero only in an inactive component
			bv = '{32'd0, 32'd0, 32'd0, 32'h00010000};
			send_vec(2'(m), av, bv);
			// tie in rounding: 1*1/2 style values
			av = '{32'd1, 32'd0, 32'd0, 32'd0};
			bv = '{32'd1, 32'd1, 32'd0, 32'd0};
			send_vec(2'(m), av, bv);
		end
		drain();
	endtask

	task automatic test_random(input int count);
		logic [31:0] av [4], bv [4];
		int kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 9);
			for (int i = 0; i < 4; i++) begin
				av[i] = rand_comp(kind < 4 ? 0 : kind < 5 ? $urandom_range(0, 3) : 3);
				bv[i] = rand_comp(kind < 4 ? 0 : kind < 5 ? $urandom_range(0, 3) : 3);
			end
			if (kind == 9)
				bv = '{32'd0, 32'd0, $urandom, $urandom};
			else if (kind == 8)
				// b equals a up to a random sign in each component
				for (int i = 0; i < 4; i++)
					bv[i] = av[i] * ($urandom_range(0, 1) ? 32'd1 : 32'hffffffff);
			send_vec(2'($urandom_range(0, 3)), av, bv);
		end
		drain();
	endtask

	// Sweep every active_dims code, out-of-range codes included.
	task automatic test_dims;
		logic [2:0] codes [8] = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd1, 3'd5, 3'd6, 3'd3};
		foreach (codes[k]) begin
			write_dims(codes[k]);
			no_gaps = (k == 1);
			test_random(k < 3 ? 250 : 40);
		end
		no_gaps = 1'b0;
	endtask

	// result checker: each transfer against the oldest prediction
	always @(posedge clk) begin
		vec_result_t exp_v;
		logic [31:0] got [4];
		if (arst_n && done) begin
			got = '{r0, r1, r2, r3};
			if (expected_vecs.size() == 0) begin
				$error("result transfer with nothing expected");
				mismatches++;
			end else begin
				exp_v = expected_vecs.pop_front();
				for (int i = 0; i < 4; i++)
					if (got[i] !== exp_v.r[i]) begin
						$error("r%0d: expected %h, got %h", i, exp_v.r[i], got[i]);
						mismatches++;
					end
				if (zero_divisor !== exp_v.zd) begin
					$error("zero_divisor: expected %b, got %b", exp_v.zd, zero_divisor);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycles = 0;
		no_gaps = 1'b0;
		dims_reg = 3'd3;
		arst_n = 1'b0;
		start = 1'b0;
		mode = '0;
		{a0, a1, a2, a3, b0, b1, b2, b3} = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200);
		test_dims();
		if (mismatches == 0 && expected_vecs.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
